/* rtl/fci_pkg.sv */
// Package: request/response types, FSM states and default curve for the fan curve interpolator.
package fci_pkg;

   localparam int unsigned TEMP_W  = 11;
   localparam int unsigned LEVEL_W = 11;
   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned PIDX_W  = 4;
   localparam int unsigned MAX_POINTS = 16;
   localparam int unsigned ACC_W   = 2 * LEVEL_W + 1;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 11'd1024;

   localparam logic [TEMP_W-1:0] DEFAULT_TEMPS [MAX_POINTS] = '{
      11'd400, 11'd480, 11'd560, 11'd640, 11'd720, 11'd800, 11'd880, 11'd960,
      11'd1040, 11'd1120, 11'd1120, 11'd1120, 11'd1120, 11'd1120, 11'd1120, 11'd1120
   };
   localparam logic [LEVEL_W-1:0] DEFAULT_LEVELS [MAX_POINTS] = '{
      11'd102, 11'd205, 11'd307, 11'd410, 11'd512, 11'd614, 11'd717, 11'd819,
      11'd922, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024
   };

   typedef struct packed {
      logic                       command;
      logic [PIDX_W-1:0]          point_index;
      logic [TEMP_W-1:0]          point_temp;
      logic [LEVEL_W-1:0]         point_level;
      logic signed [SAMPLE_W-1:0] temperature;
   } fci_req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] fan_level;
      logic               held;
   } fci_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_P0,
      ST_PLAST,
      ST_SEARCH,
      ST_MUL1,
      ST_MUL2,
      ST_DIV,
      ST_DONE
   } fci_state_type;

endpackage

/* rtl/fan_curve_interpolator.sv */
// Top level: piecewise-linear fan curve with a point RAM, segment walk and serial divider.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_valid / req_stall | fci_req_type (load point or sample)
//   rsp     | out | rsp_valid / rsp_stall | fci_rsp_type (fan level, held flag)
//
// A load request is taken in the idle state and gives no response.
// A sample reads the first and last points, walks the segments in the point RAM and,
// when interpolating, passes through the multiply states ST_MUL1 and ST_MUL2 and the
// serial divider, then loads the response register before the next request is taken.
// After reset the default curve is in effect: unwritten points read from the package table.
// A waiting response does not block the next request; the next result waits for rsp_stall low.
module fan_curve_interpolator #(
   parameter int unsigned CURVE_POINTS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fci_pkg::fci_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fci_pkg::fci_rsp_type rsp_data
);
   import fci_pkg::*;

   localparam int unsigned IDX_W = $clog2(CURVE_POINTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CURVE_POINTS - 1);
   localparam logic [IDX_W-1:0] LAST_SEG = IDX_W'(CURVE_POINTS - 2);
   localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
   localparam logic [4:0]       DIV_STEPS_M1 = 5'(ACC_W - 1);

   fci_state_type state_ff, state_in;

   // point RAM and per-point valid bits
   logic                            ram_we;
   logic [IDX_W-1:0]                ram_waddr;
   logic [IDX_W-1:0]                ram_raddr;
   logic [TEMP_W+LEVEL_W-1:0]       ram_q;
   logic [IDX_W-1:0]                rd_addr_ff;
   logic [CURVE_POINTS-1:0]         pt_valid_ff, pt_valid_in;
   logic [TEMP_W-1:0]               rd_temp;
   logic [LEVEL_W-1:0]              rd_level;

   // datapath
   logic signed [SAMPLE_W-1:0] t_ff, t_in;
   logic [TEMP_W-1:0]          ta_ff, ta_in;
   logic [LEVEL_W-1:0]         la_ff, la_in;
   logic [LEVEL_W-1:0]         lb_ff, lb_in;
   logic [TEMP_W-1:0]          dhi_ff, dhi_in;
   logic [TEMP_W-1:0]          dlo_ff, dlo_in;
   logic [TEMP_W-1:0]          den_ff, den_in;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic [TEMP_W-1:0]          rem_ff, rem_in;
   logic [4:0]                 div_cnt_ff, div_cnt_in;
   logic [IDX_W-1:0]           seg_ff, seg_in;
   logic [LEVEL_W-1:0]         res_ff, res_in;
   logic                       held_ff, held_in;
   logic [LEVEL_W-1:0]         last_level_ff, last_level_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   fci_rsp_type                rsp_data_ff, rsp_data_in;

   // comparisons and step results
   logic                       req_fire;
   logic                       load_hit;
   logic                       out_free;
   logic signed [SAMPLE_W-1:0] ta_s, tb_s;
   logic                       t_nonneg;
   logic                       in_origin;
   logic                       at_last;
   logic                       in_seg;
   logic [SAMPLE_W-1:0]        diff_hi, diff_lo, width;
   logic [IDX_W:0]             seg_next2;
   logic [TEMP_W:0]            trial;
   logic                       trial_ge;
   logic [2*LEVEL_W-1:0]       prod;

   function automatic logic [LEVEL_W-1:0] clamp_level(input logic [ACC_W-1:0] v);
      if (v > ACC_W'(LEVEL_MAX)) begin
         return LEVEL_MAX;
      end
      return v[LEVEL_W-1:0];
   endfunction

   fci_ram #(
      .WIDTH(TEMP_W + LEVEL_W),
      .DEPTH(CURVE_POINTS)
   ) u_points (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data({req_data.point_temp, req_data.point_level}),
      .rd_addr(ram_raddr),
      .rd_data(ram_q)
   );

   // points never written read as the default curve
   assign rd_temp  = pt_valid_ff[rd_addr_ff] ? ram_q[TEMP_W+LEVEL_W-1:LEVEL_W]
                                             : DEFAULT_TEMPS[PIDX_W'(rd_addr_ff)];
   assign rd_level = pt_valid_ff[rd_addr_ff] ? ram_q[LEVEL_W-1:0]
                                             : DEFAULT_LEVELS[PIDX_W'(rd_addr_ff)];

   assign req_fire  = req_valid && !req_stall;
   assign load_hit  = ({1'b0, req_data.point_index} < (PIDX_W+1)'(CURVE_POINTS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign ta_s      = $signed({1'b0, ta_ff});
   assign tb_s      = $signed({1'b0, rd_temp});
   assign t_nonneg  = !t_ff[SAMPLE_W-1];
   assign in_origin = t_nonneg && (t_ff <= ta_s);
   assign at_last   = (t_ff >= tb_s);
   assign in_seg    = (t_ff >= ta_s) && (t_ff <= tb_s);
   assign diff_hi   = SAMPLE_W'(tb_s - t_ff);
   assign diff_lo   = SAMPLE_W'(t_ff - ta_s);
   assign width     = SAMPLE_W'(tb_s - ta_s);
   assign seg_next2 = {1'b0, seg_ff} + (IDX_W+1)'(2);

   assign trial     = {rem_ff, acc_ff[ACC_W-1]};
   assign trial_ge  = (trial >= {1'b0, den_ff});
   assign prod      = (state_ff == ST_MUL1) ? la_ff * dhi_ff : lb_ff * dlo_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.command == CMD_SAMPLE) begin
               state_in = ST_P0;
            end
         end
         ST_P0: begin
            state_in = ST_PLAST;
         end
         ST_PLAST: begin
            if (in_origin) begin
               state_in = (ta_ff == '0) ? ST_DONE : ST_MUL1;
            end else if (at_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (in_seg) begin
               state_in = (width == '0) ? ST_DONE : ST_MUL1;
            end else if (seg_ff == LAST_SEG) begin
               state_in = ST_DONE;
            end
         end
         ST_MUL1: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      ram_we    = 1'b0;
      ram_waddr = req_data.point_index[IDX_W-1:0];
      ram_raddr = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            ram_we    = req_valid && req_data.command == CMD_LOAD && load_hit;
         end
         ST_P0: begin
            ram_raddr = LAST_IDX;
         end
         ST_PLAST: begin
            ram_raddr = IDX_ONE;
         end
         ST_SEARCH: begin
            if (seg_ff != LAST_SEG) begin
               ram_raddr = seg_next2[IDX_W-1:0];
            end
         end
         default: begin
            ram_raddr = '0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      pt_valid_in   = pt_valid_ff;
      t_in          = t_ff;
      ta_in         = ta_ff;
      la_in         = la_ff;
      lb_in         = lb_ff;
      dhi_in        = dhi_ff;
      dlo_in        = dlo_ff;
      den_in        = den_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      seg_in        = seg_ff;
      res_in        = res_ff;
      held_in       = held_ff;
      last_level_in = last_level_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      if (ram_we) begin
         pt_valid_in[ram_waddr] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            t_in = req_data.temperature;
         end
         ST_P0: begin
            ta_in = rd_temp;
            la_in = rd_level;
         end
         ST_PLAST: begin
            held_in = 1'b0;
            seg_in  = '0;
            if (in_origin) begin
               // line from the origin: la0 * t / ta0
               res_in = '0;
               dhi_in = t_ff[TEMP_W-1:0];
               lb_in  = '0;
               dlo_in = '0;
               den_in = ta_ff;
            end else if (at_last) begin
               res_in = clamp_level(ACC_W'(rd_level));
            end
         end
         ST_SEARCH: begin
            if (in_seg) begin
               res_in = clamp_level(ACC_W'(la_ff));
               dhi_in = diff_hi[TEMP_W-1:0];
               dlo_in = diff_lo[TEMP_W-1:0];
               lb_in  = rd_level;
               den_in = width[TEMP_W-1:0];
            end else begin
               ta_in = rd_temp;
               la_in = rd_level;
               seg_in = seg_ff + IDX_ONE;
               if (seg_ff == LAST_SEG) begin
                  held_in = 1'b1;
               end
            end
         end
         ST_MUL1: begin
            acc_in = ACC_W'(prod);
         end
         ST_MUL2: begin
            acc_in     = acc_ff + ACC_W'(prod);
            rem_in     = '0;
            div_cnt_in = DIV_STEPS_M1;
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            rem_in     = trial_ge ? TEMP_W'(trial - {1'b0, den_ff}) : trial[TEMP_W-1:0];
            acc_in     = {acc_ff[ACC_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff - 5'd1;
            if (div_cnt_ff == '0) begin
               res_in = clamp_level({acc_ff[ACC_W-2:0], trial_ge});
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (held_ff) begin
                  rsp_data_in.fan_level = last_level_ff;
                  rsp_data_in.held      = 1'b1;
               end else begin
                  rsp_data_in.fan_level = res_ff;
                  rsp_data_in.held      = 1'b0;
                  last_level_in         = res_ff;
               end
            end
         end
         default: begin
            held_in = held_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pt_valid_ff   <= '0;
         last_level_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pt_valid_ff   <= pt_valid_in;
         last_level_ff <= last_level_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= ram_raddr;
      t_ff        <= t_in;
      ta_ff       <= ta_in;
      la_ff       <= la_in;
      lb_ff       <= lb_in;
      dhi_ff      <= dhi_in;
      dlo_ff      <= dlo_in;
      den_ff      <= den_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      seg_ff      <= seg_in;
      res_ff      <= res_in;
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/fci_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module fci_ram #(
   parameter int unsigned WIDTH = 22,
   parameter int unsigned DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/tb.sv */
// Testbench for fan_curve_interpolator: random point loads and samples checked against a level predictor.
module tb;
   import fci_pkg::*;

   localparam int N           = 10;
   localparam int ITEM_TARGET = 1500;
   localparam int QUIET_TAIL  = 120;
   localparam int DRAIN       = 64;
   localparam int CYCLE_LIMIT = 1000000;

   // Curve state copy plus the queue of fan levels still owed by the block.
   class fan_level_predictor;
      logic [TEMP_W-1:0]  curve_temps [MAX_POINTS];
      logic [LEVEL_W-1:0] curve_levels [MAX_POINTS];
      logic [LEVEL_W-1:0] last_level;
      fci_rsp_type        expected_levels [$];
      int                 mismatch_count;

      function new();
         for (int i = 0; i < MAX_POINTS; i++) begin
            curve_temps[i]  = DEFAULT_TEMPS[i];
            curve_levels[i] = DEFAULT_LEVELS[i];
         end
         last_level     = '0;
         mismatch_count = 0;
      endfunction

      function void take_request(input fci_req_type r);
         longint      t, lvl, ta, tb, la, lb, w;
         bit          hit;
         fci_rsp_type e;
         if (r.command == CMD_LOAD) begin
            if (r.point_index < N) begin
               curve_temps[r.point_index]  = r.point_temp;
               curve_levels[r.point_index] = r.point_level;
            end
            return;
         end
         t   = $signed(r.temperature);
         hit = 1'b1;
         lvl = 0;
         ta  = curve_temps[0];
         la  = curve_levels[0];
         tb  = curve_temps[N-1];
         if (t >= 0 && t <= ta) begin
            // line from the origin to the first point
            lvl = (ta == 0) ? 0 : (la * t) / ta;
         end else if (t >= tb) begin
            lvl = curve_levels[N-1];
         end else begin
            hit = 1'b0;
            for (int i = 0; i < N - 1; i++) begin
               ta = curve_temps[i];
               tb = curve_temps[i+1];
               la = curve_levels[i];
               lb = curve_levels[i+1];
               if (t >= ta && t <= tb) begin
                  w   = tb - ta;
                  lvl = (w == 0) ? la : (la * w + (lb - la) * (t - ta)) / w;
                  hit = 1'b1;
                  break;
               end
            end
         end
         if (hit) begin
            if (lvl < 0) lvl = 0;
            if (lvl > longint'(LEVEL_MAX)) lvl = LEVEL_MAX;
            last_level = lvl[LEVEL_W-1:0];
            e.held     = 1'b0;
         end else begin
            e.held = 1'b1;
         end
         e.fan_level = last_level;
         expected_levels.push_back(e);
      endfunction

      function void check_level(input fci_rsp_type a);
         fci_rsp_type e;
         if (expected_levels.size() == 0) begin
            $display("%0t: response with none expected: fan_level %0d held %0b",
                     $time, a.fan_level, a.held);
            mismatch_count++;
            return;
         end
         e = expected_levels.pop_front();
         if (a.fan_level !== e.fan_level) begin
            $display("%0t: fan_level expected %0d actual %0d", $time, e.fan_level, a.fan_level);
            mismatch_count++;
         end
         if (a.held !== e.held) begin
            $display("%0t: held expected %0b actual %0b", $time, e.held, a.held);
            mismatch_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   fci_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   fci_rsp_type rsp_data;

   fan_level_predictor sb = new();
   int                 issued = 0;
   bit                 quiet = 1'b0;
   int                 cycle_count = 0;

   fan_curve_interpolator #(.CURVE_POINTS(N)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("fan_curve_interpolator: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.take_request(req_data);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_level(rsp_data);
   end

   // Response backpressure: random stall bursts between open stretches.
   always begin
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(0, 12)) @(negedge clock);
      end else begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(0, 20)) @(negedge clock);
      end
   end

   task automatic send_request(input fci_req_type r);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic load_point(input int idx, input int temp, input int lvl);
      fci_req_type r;
      r.command     = CMD_LOAD;
      r.point_index = PIDX_W'(idx);
      r.point_temp  = TEMP_W'(temp);
      r.point_level = LEVEL_W'(lvl);
      r.temperature = SAMPLE_W'($urandom);
      if (idx < N) issued++;
      send_request(r);
   endtask

   task automatic sample(input int temp);
      fci_req_type r;
      r.command     = CMD_SAMPLE;
      r.point_index = PIDX_W'($urandom);
      r.point_temp  = TEMP_W'($urandom);
      r.point_level = LEVEL_W'($urandom);
      r.temperature = SAMPLE_W'(temp);
      issued++;
      send_request(r);
   endtask

   function automatic int pick_temperature();
      int lo, hi;
      lo = sb.curve_temps[0];
      hi = sb.curve_temps[N-1];
      case ($urandom_range(0, 9))
         0, 1:    return $urandom_range(0, 4095) - 2048;
         2:       return -$urandom_range(1, 2048);
         3, 4:    return int'(sb.curve_temps[$urandom_range(0, N-1)]) + $urandom_range(0, 2) - 1;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   initial begin
      int pts [N];
      int order [N];
      int span;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: default curve, extremes, ignored load, clamping, odd tables
      sample(0);
      sample(200);
      sample(400);
      sample(1000);
      sample(2047);
      sample(-2048);
      sample(-1);
      load_point(15, 0, 0);
      sample(1120);
      load_point(9, 2047, 2047);
      sample(1100);
      sample(2047);
      load_point(0, 0, 1024);
      sample(0);
      sample(1);
      load_point(2, 480, 700);
      sample(480);
      load_point(5, 100, 50);
      sample(700);
      load_point(9, 0, 333);
      sample(5);
      sample(-5);

      while (issued < ITEM_TARGET) begin
         if ($urandom_range(0, 7) != 0) begin
            // fresh sorted curve, loaded in shuffled order; narrow spans give duplicates
            span = ($urandom_range(0, 5) == 0) ? 63 : 2047;
            foreach (pts[k]) pts[k] = $urandom_range(0, span);
            pts.sort();
            foreach (order[k]) order[k] = k;
            order.shuffle();
            foreach (order[k])
               load_point(order[k], pts[order[k]],
                          ($urandom_range(0, 9) == 0) ? $urandom_range(1025, 2047)
                                                      : $urandom_range(0, 1024));
         end
         repeat ($urandom_range(20, 60)) begin
            if ($urandom_range(0, 24) == 0)
               load_point($urandom_range(0, 15), $urandom_range(0, 2047),
                          $urandom_range(0, 2047));
            else
               sample(pick_temperature());
         end
         if (issued >= ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_levels.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.expected_levels.size() == 0)
         $display("fan_curve_interpolator: match");
      else
         $display("fan_curve_interpolator: mismatch");
      $finish;
   end

endmodule
